FILE: rtl/p2g_pkg.sv
// Shared types and constants for the pixel to glyph mapper.
// Holds the sequencer states, the divider request/response structs and the glyph tables.
// No dependencies.
package p2g_pkg;

    localparam int DivW = 15;   // dividend and quotient width
    localparam int DsrW = 9;    // divisor width
    localparam int CntW = 4;    // step counter width

    localparam logic [5:0] BrailleHi  = 6'h28;  // upper bits of 0x2800
    localparam logic [6:0] RampMid    = 7'd45;
    localparam logic [6:0] RampLast   = 7'd90;
    localparam logic [6:0] RampScale  = 7'd90;
    localparam logic [8:0] LevelsMax  = 9'd256;
    localparam logic [DivW-1:0] FullRange = 15'd256;
    localparam logic [CntW-1:0] StepsShort = 4'd9;
    localparam logic [CntW-1:0] StepsLong  = 4'd15;

    localparam logic [7:0] RampChars [0:90] = '{
        8'h60, 8'h2E, 8'h2D, 8'h27, 8'h3A, 8'h5F, 8'h2C, 8'h5E, 8'h3D, 8'h3B,
        8'h3E, 8'h3C, 8'h2B, 8'h21, 8'h72, 8'h63, 8'h2A, 8'h2F,
        8'h7A, 8'h3F, 8'h73, 8'h4C, 8'h54, 8'h76, 8'h29, 8'h4A, 8'h37, 8'h28,
        8'h7C, 8'h46, 8'h69, 8'h7B, 8'h43, 8'h7D, 8'h66, 8'h49, 8'h33, 8'h31,
        8'h74, 8'h6C, 8'h75, 8'h5B, 8'h6E, 8'h65, 8'h6F, 8'h5A, 8'h35, 8'h59,
        8'h78, 8'h6A, 8'h79, 8'h61, 8'h5D, 8'h32, 8'h45, 8'h53, 8'h77, 8'h71,
        8'h6B, 8'h50, 8'h36, 8'h68, 8'h39, 8'h64, 8'h34, 8'h56, 8'h70, 8'h4F,
        8'h47, 8'h62, 8'h55, 8'h41, 8'h4B, 8'h58, 8'h48, 8'h6D, 8'h38, 8'h52,
        8'h44, 8'h23, 8'h24, 8'h42, 8'h67, 8'h30, 8'h4D, 8'h4E, 8'h57, 8'h51,
        8'h25, 8'h26, 8'h40
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_BRIGHT,
        S_BRL,
        S_DIV1,
        S_DIV2,
        S_SCALE,
        S_DIV3,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [DsrW-1:0] divisor;
        logic [CntW-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [DivW-1:0] quotient;
    } t_div_rsp;

    // Dots set by the first num entries of the fill order 0,3,1,4,2,5,6,7.
    function automatic logic [7:0] fill_mask(input logic [2:0] num);
        logic [7:0] m;
        case (num)
            3'd0:    m = 8'h00;
            3'd1:    m = 8'h01;
            3'd2:    m = 8'h09;
            3'd3:    m = 8'h0B;
            3'd4:    m = 8'h1B;
            3'd5:    m = 8'h1F;
            3'd6:    m = 8'h3F;
            default: m = 8'h7F;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/pixel_to_glyph_mapper.sv
// Pixel to glyph mapper: brightness ramp characters or braille cells from RGB pixels.
// Ramp mode with two or more levels makes three passes through the shared bit-serial
// divider of 9, 9 and 15 steps; ramp mode with one level and braille mode skip it.
// A pixel is taken only after the previous one is done; a braille pixel not last in its cell
// gives no result, and a result waits in the output register while the next pixel is taken.
// Synchronous active-low reset clears mode, dots and cell color and sets levels to one.
module pixel_to_glyph_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [2:0]  i_cell_slot,
    input  logic        i_cell_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [13:0] o_code_point,
    output logic [7:0]  o_color_red,
    output logic [7:0]  o_color_green,
    output logic [7:0]  o_color_blue
);
    import p2g_pkg::*;

    localparam logic CfgMode   = 1'b0;
    localparam logic CfgLevels = 1'b1;

    t_state      r_state, n_state;
    logic        r_mode;
    logic [8:0]  r_levels;
    logic [7:0]  r_red, r_green, r_blue;
    logic [2:0]  r_slot;
    logic        r_last;
    logic [7:0]  r_bright;
    logic [7:0]  r_q;
    logic [13:0] r_res_code;
    logic [7:0]  r_dots;
    logic [23:0] r_cell_color;
    logic        r_o_valid;
    logic [13:0] r_o_code;
    logic [23:0] r_o_color;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic        in_take;
    logic        out_free;
    logic [8:0]  lv;
    logic        lv_pow2;
    logic [9:0]  rgb_sum;
    logic [19:0] third_prod;
    logic [8:0]  step_d1;
    logic [8:0]  round_num;
    logic [8:0]  q_max;
    logic [7:0]  q_clamped;
    logic [14:0] scaled;
    logic [6:0]  ramp_idx;
    logic [7:0]  new_dots;
    logic [23:0] new_color;

    p2g_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    // Saturate levels into 1..256.
    always_comb begin
        if (r_levels == 9'd0) begin
            lv = 9'd1;
        end else if (r_levels > LevelsMax) begin
            lv = LevelsMax;
        end else begin
            lv = r_levels;
        end
    end
    assign lv_pow2 = (lv & (lv - 9'd1)) == 9'd0;

    // floor(sum/3) as sum*683 >> 11, exact for sums up to 765.
    assign rgb_sum    = 10'(r_red) + 10'(r_green) + 10'(r_blue);
    assign third_prod = 20'(rgb_sum) * 20'd683;

    // 255/lv equals 256/lv less one exactly when lv is a power of two.
    assign step_d1   = div_rsp.quotient[8:0] - 9'(lv_pow2);
    assign round_num = 9'(r_bright) + 9'(step_d1[8:1]);

    assign q_max     = lv - 9'd1;
    assign q_clamped = (div_rsp.quotient >= 15'(q_max)) ? q_max[7:0] : div_rsp.quotient[7:0];
    assign scaled    = 15'(r_q) * 15'(RampScale);
    assign ramp_idx  = (div_rsp.quotient > 15'(RampLast)) ? RampLast : div_rsp.quotient[6:0];

    assign new_dots  = (r_dots & ~(8'd1 << r_slot)) | fill_mask(r_bright[7:5]);
    assign new_color = (r_slot == 3'd0) ? {r_red, r_green, r_blue} : r_cell_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = FullRange;
        div_req.divisor  = lv;
        div_req.steps    = StepsShort;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) n_state = S_BRIGHT;
            end
            S_BRIGHT: begin
                if (r_mode) begin
                    n_state = S_BRL;
                end else if (lv == 9'd1) begin
                    n_state = S_EMIT;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV1;
                end
            end
            S_BRL: begin
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_DIV1: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 15'(round_num);
                    div_req.divisor  = div_rsp.quotient[8:0];
                    n_state          = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_rsp.done) n_state = S_SCALE;
            end
            S_SCALE: begin
                div_req.start    = 1'b1;
                div_req.dividend = scaled;
                div_req.divisor  = q_max;
                div_req.steps    = StepsLong;
                n_state          = S_DIV3;
            end
            S_DIV3: begin
                if (div_rsp.done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration and cell state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_levels     <= 9'd1;
            r_dots       <= '0;
            r_cell_color <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CfgMode)   r_mode   <= i_cfg_wdata[0];
            if (i_cfg_we && i_cfg_index == CfgLevels) r_levels <= i_cfg_wdata;
            if (r_state == S_BRL) begin
                r_cell_color <= new_color;
                r_dots       <= r_last ? 8'd0 : new_dots;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_slot  <= i_cell_slot;
            r_last  <= i_cell_last;
        end
        if (r_state == S_BRIGHT) begin
            r_bright   <= third_prod[18:11];
            r_res_code <= {6'd0, RampChars[RampMid]};
        end
        if (r_state == S_BRL) r_res_code <= {BrailleHi, new_dots};
        if (r_state == S_DIV2 && div_rsp.done) r_q <= q_clamped;
        if (r_state == S_DIV3 && div_rsp.done) r_res_code <= {6'd0, RampChars[ramp_idx]};
    end

    // Output register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_o_code  <= r_res_code;
            r_o_color <= r_mode ? r_cell_color : {r_red, r_green, r_blue};
        end
    end

    assign o_valid       = r_o_valid;
    assign o_code_point  = r_o_code;
    assign o_color_red   = r_o_color[23:16];
    assign o_color_green = r_o_color[15:8];
    assign o_color_blue  = r_o_color[7:0];

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> o_stall)
        else $error("request accepted while divider busy");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_EMIT))
        else $error("result loaded outside emit state");

    a_dots_clear_after_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BRL && r_last) |=> (r_dots == 8'd0))
        else $error("dot pattern not cleared after cell");

    a_divider_only_in_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !r_mode && lv != 9'd1)
        else $error("divider started without ramp quantization");

endmodule

FILE: rtl/p2g_div.sv
// Restoring radix-2 divider shared by all quantization steps.
// One quotient bit per cycle; the step count selects how many dividend bits are used.
// Depends on p2g_pkg.
module p2g_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  p2g_pkg::t_div_req   i_req,
    output p2g_pkg::t_div_rsp   o_rsp
);
    import p2g_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [DivW-1:0] r_num;
    logic [DsrW-1:0] r_rem;
    logic [DsrW-1:0] r_dsr;

    logic [DsrW:0]   trial;
    logic            fits;
    logic [CntW-1:0] pre_shift;

    assign trial     = {r_rem, r_num[DivW-1]};
    assign fits      = trial >= {1'b0, r_dsr};
    assign pre_shift = CntW'(DivW) - i_req.steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end
        end
    end

    // Quotient bits shift in at the bottom as the dividend bits leave the top.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= fits ? DsrW'(trial - {1'b0, r_dsr}) : trial[DsrW-1:0];
            r_num <= {r_num[DivW-2:0], fits};
        end else if (i_req.start) begin
            r_rem <= '0;
            r_dsr <= i_req.divisor;
            r_num <= i_req.dividend << pre_shift;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule
